// File: hdl/idc_pkg.sv
// Shared types and constants for the inverse-depth to Cartesian converter.
`timescale 1ns / 1ps

package idc_pkg;

  localparam int InvW    = 24;
  localparam int AngW    = 16;
  localparam int CoordW  = 32;
  localparam int RangeW  = 31;
  localparam int NumW    = 37;
  localparam int DivW    = 23;
  localparam int UW      = 15;
  localparam int NumCells    = NumW;
  localparam int SineStages  = 7;

  localparam logic [RangeW-1:0] FarRangeReset = 31'd65536000;
  localparam logic [RangeW-1:0] RangeMax      = {RangeW{1'b1}};
  localparam logic [NumW-1:0]   NumOne        = 37'h10_0000_0000;
  localparam logic [UW-1:0]     QuarterTurn   = 15'd16384;

  localparam logic signed [32:0] SinC1 = 33'sd1686629713;
  localparam logic signed [32:0] SinC3 = -33'sd693598669;
  localparam logic signed [32:0] SinC5 = 33'sd85569321;
  localparam logic signed [32:0] SinC7 = -33'sd5026990;
  localparam logic signed [32:0] SinC9 = 33'sd172271;
  localparam logic signed [35:0] Q30One  = 36'sd1073741824;
  localparam logic signed [63:0] Q30Half = 64'sd536870912;

  typedef enum logic [1:0] {
    RANGE_DIV,
    RANGE_ZERO,
    RANGE_FAR
  } range_mode_t;

  typedef struct packed {
    logic              valid;
    range_mode_t       mode;
    logic [AngW-1:0]   yaw;
    logic [AngW-1:0]   pitch;
    logic [DivW-1:0]   divisor;
    logic [DivW-1:0]   rem;
    logic [NumW-1:0]   num;
    logic [NumW-1:0]   quo;
  } div_stage_t;

  typedef struct packed {
    logic              valid;
    logic [RangeW-1:0] r;
    logic [1:0]        qy;
    logic [1:0]        qp;
  } side_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } coord_t;

endpackage

// File: hdl/idc_point_if.sv
// Input channel carrying one inverse-depth point.
`timescale 1ns / 1ps

interface idc_point_if import idc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [InvW-1:0] inverse_range;
  logic signed [AngW-1:0] yaw_angle;
  logic signed [AngW-1:0] pitch_angle;

  modport source(output valid, inverse_range, yaw_angle, pitch_angle, input ready);
  modport sink(input valid, inverse_range, yaw_angle, pitch_angle, output ready);
endinterface

// File: hdl/idc_coord_if.sv
// Output channel carrying one Cartesian point.
`timescale 1ns / 1ps

interface idc_coord_if import idc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] x_coord;
  logic signed [CoordW-1:0] y_coord;
  logic signed [CoordW-1:0] z_coord;

  modport source(output valid, x_coord, y_coord, z_coord, input ready);
  modport sink(input valid, x_coord, y_coord, z_coord, output ready);
endinterface

// File: hdl/idc_cfg_if.sv
// Configuration write channel for the far-range register.
`timescale 1ns / 1ps

interface idc_cfg_if import idc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RangeW-1:0] far_range_value;

  modport source(output valid, far_range_value, input ready);
  modport sink(input valid, far_range_value, output ready);
endinterface

// File: hdl/idc_div_cell.sv
// One restoring-division cell: produces one quotient bit and passes the item on.
`timescale 1ns / 1ps

module idc_div_cell import idc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  div_stage_t d,
  output div_stage_t q
);

  logic [DivW:0] trial;
  logic          fits;
  div_stage_t    q_next;

  always_comb begin
    trial  = {d.rem, d.num[NumW-1]};
    fits   = trial >= {1'b0, d.divisor};
    q_next = d;
    // When the trial is below the divisor it is also below 2^23, so the top bit is zero.
    q_next.rem = fits ? DivW'(trial - {1'b0, d.divisor}) : trial[DivW-1:0];
    q_next.num = {d.num[NumW-2:0], 1'b0};
    q_next.quo = {d.quo[NumW-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q <= q_next;
    end
  end

endmodule

// File: hdl/idc_quarter_sine.sv
// Pipelined quarter-wave sine polynomial, Q30 result clamped to [0, 1].
`timescale 1ns / 1ps

module idc_quarter_sine import idc_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [UW-1:0]        u,
  output logic signed [31:0]   s
);

  logic [30:0]          t_in;
  logic [30:0]          t1, t2, t3, t4, t5;
  logic [61:0]          tt1;
  logic signed [31:0]   w2, w3, w4, w5;
  logic signed [65:0]   prod2, prod3, prod4, prod5, prod6;
  logic signed [32:0]   p3, p4, p5, p6;
  logic signed [35:0]   poly;

  assign t_in = {u, 16'b0};

  always_comb begin
    p3   = SinC7 + 33'(prod2 >>> 30);
    p4   = SinC5 + 33'(prod3 >>> 30);
    p5   = SinC3 + 33'(prod4 >>> 30);
    p6   = SinC1 + 33'(prod5 >>> 30);
    poly = 36'(prod6 >>> 30);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1    <= t_in;
      tt1   <= t_in * t_in;
      t2    <= t1;
      w2    <= $signed({1'b0, tt1[60:30]});
      prod2 <= SinC9 * $signed({1'b0, tt1[60:30]});
      t3    <= t2;
      w3    <= w2;
      prod3 <= p3 * w2;
      t4    <= t3;
      w4    <= w3;
      prod4 <= p4 * w3;
      t5    <= t4;
      w5    <= w4;
      prod5 <= p5 * w4;
      prod6 <= p6 * $signed({1'b0, t5});
      if (poly < 0) begin
        s <= '0;
      end else if (poly > Q30One) begin
        s <= 32'(Q30One);
      end else begin
        s <= 32'(poly);
      end
    end
  end

endmodule

// File: hdl/inverse_depth_to_cartesian.sv
// Top level: inverse-depth point to Cartesian x, y, z converter.
// Usage:
//   points carries inverse_range (Q4.20), yaw_angle and pitch_angle (binary
//   angles); an item is taken when valid and ready are both high.
//   coords returns x_coord, y_coord, z_coord in signed Q16.16, one item for
//   every input item, in order.
//   cfg writes the far-range register, used as the range for negative inverse
//   range; write it only while no item is in flight. It is always ready.
// Throughput is one item per clock unless the pipeline holds. Between
// acceptance and coords.valid lie 37 division cells (one quotient bit each),
// one range stage, the 7-stage sine polynomial, one sign-select stage and
// three product stages. A two-entry output buffer sits at the end, so a new
// item is still taken while one finished result waits. When both entries are
// full the whole pipeline holds and points.ready drops; nothing is lost.
// Reset clears every pipeline valid bit, empties the output buffer and loads
// the far-range register with 1000 m.
`timescale 1ns / 1ps

module inverse_depth_to_cartesian import idc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  idc_point_if.sink    points,
  idc_coord_if.source  coords,
  idc_cfg_if.sink      cfg
);

  logic              adv;
  logic [RangeW-1:0] far_range;
  div_stage_t        chain [NumCells+1];
  div_stage_t        last;

  side_t             prep;
  logic [UW-1:0]     yf, yc, pf, pc;
  side_t             side_d [SineStages];
  logic signed [31:0] s_yf, s_yc, s_pf, s_pc;

  logic               sel_valid;
  logic signed [31:0] sel_r, cy, sy, cp, sp;
  logic signed [31:0] cy_next, sy_next, cp_next, sp_next;

  logic               m_valid;
  logic signed [63:0] mx, my, mz;
  logic signed [31:0] m_cp;
  logic signed [31:0] ax, ay;
  logic               n_valid;
  logic signed [63:0] nx, ny;
  logic signed [31:0] nz;
  logic               o_valid;
  coord_t             o_pt;

  coord_t             fifo_mem [2];
  logic               wr_ptr, rd_ptr;
  logic [1:0]         count, count_next;
  logic               push, pop;

  assign adv          = (count != 2'd2);
  assign points.ready = adv;
  assign cfg.ready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      far_range <= FarRangeReset;
    end else if (cfg.valid) begin
      far_range <= cfg.far_range_value;
    end
  end

  // Numerator is 2^36 plus half the divisor, so the quotient rounds to nearest.
  always_comb begin
    chain[0].valid   = points.valid;
    if (points.inverse_range[InvW-1]) begin
      chain[0].mode = RANGE_FAR;
    end else if (points.inverse_range == '0) begin
      chain[0].mode = RANGE_ZERO;
    end else begin
      chain[0].mode = RANGE_DIV;
    end
    chain[0].yaw     = points.yaw_angle;
    chain[0].pitch   = points.pitch_angle;
    chain[0].divisor = points.inverse_range[DivW-1:0];
    chain[0].rem     = '0;
    chain[0].num     = NumOne + NumW'(points.inverse_range[DivW-1:1]);
    chain[0].quo     = '0;
  end

  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    idc_div_cell u_cell (
      .clk (clk),
      .rst (rst),
      .en  (adv),
      .d   (chain[k]),
      .q   (chain[k+1])
    );
  end

  assign last = chain[NumCells];

  always_ff @(posedge clk) begin
    if (rst) begin
      prep.valid <= 1'b0;
    end else if (adv) begin
      prep.valid <= last.valid;
      case (last.mode)
        RANGE_FAR:  prep.r <= far_range;
        RANGE_ZERO: prep.r <= '0;
        default:    prep.r <= (|last.quo[NumW-1:RangeW]) ? RangeMax : last.quo[RangeW-1:0];
      endcase
      prep.qy <= last.yaw[AngW-1:AngW-2];
      prep.qp <= last.pitch[AngW-1:AngW-2];
      yf      <= {1'b0, last.yaw[AngW-3:0]};
      yc      <= QuarterTurn - {1'b0, last.yaw[AngW-3:0]};
      pf      <= {1'b0, last.pitch[AngW-3:0]};
      pc      <= QuarterTurn - {1'b0, last.pitch[AngW-3:0]};
    end
  end

  idc_quarter_sine u_s_yf (.clk(clk), .en(adv), .u(yf), .s(s_yf));
  idc_quarter_sine u_s_yc (.clk(clk), .en(adv), .u(yc), .s(s_yc));
  idc_quarter_sine u_s_pf (.clk(clk), .en(adv), .u(pf), .s(s_pf));
  idc_quarter_sine u_s_pc (.clk(clk), .en(adv), .u(pc), .s(s_pc));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SineStages; k++) begin
        side_d[k].valid <= 1'b0;
      end
    end else if (adv) begin
      side_d[0] <= prep;
      for (int k = 1; k < SineStages; k++) begin
        side_d[k] <= side_d[k-1];
      end
    end
  end

  // Odd quadrants mirror the quarter wave; cosine is the sine a quarter turn ahead.
  always_comb begin
    sy_next = side_d[SineStages-1].qy[0] ? s_yc : s_yf;
    cy_next = side_d[SineStages-1].qy[0] ? s_yf : s_yc;
    sp_next = side_d[SineStages-1].qp[0] ? s_pc : s_pf;
    cp_next = side_d[SineStages-1].qp[0] ? s_pf : s_pc;
    if (side_d[SineStages-1].qy[1]) begin
      sy_next = -sy_next;
    end
    if (side_d[SineStages-1].qy[1] ^ side_d[SineStages-1].qy[0]) begin
      cy_next = -cy_next;
    end
    if (side_d[SineStages-1].qp[1]) begin
      sp_next = -sp_next;
    end
    if (side_d[SineStages-1].qp[1] ^ side_d[SineStages-1].qp[0]) begin
      cp_next = -cp_next;
    end
  end

  always_comb begin
    ax = 32'((mx + Q30Half) >>> 30);
    ay = 32'((my + Q30Half) >>> 30);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel_valid <= 1'b0;
      m_valid   <= 1'b0;
      n_valid   <= 1'b0;
      o_valid   <= 1'b0;
    end else if (adv) begin
      sel_valid <= side_d[SineStages-1].valid;
      sel_r     <= $signed({1'b0, side_d[SineStages-1].r});
      cy        <= cy_next;
      sy        <= sy_next;
      cp        <= cp_next;
      sp        <= sp_next;

      m_valid <= sel_valid;
      mx      <= sel_r * cy;
      my      <= sel_r * sy;
      mz      <= sel_r * sp;
      m_cp    <= cp;

      n_valid <= m_valid;
      nx      <= ax * m_cp;
      ny      <= ay * m_cp;
      nz      <= -(32'((mz + Q30Half) >>> 30));

      o_valid <= n_valid;
      o_pt.x  <= 32'((nx + Q30Half) >>> 30);
      o_pt.y  <= 32'((ny + Q30Half) >>> 30);
      o_pt.z  <= nz;
    end
  end

  assign push = adv && o_valid;
  assign pop  = coords.valid && coords.ready;

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= o_pt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  assign coords.valid   = (count != 2'd0);
  assign coords.x_coord = fifo_mem[rd_ptr].x;
  assign coords.y_coord = fifo_mem[rd_ptr].y;
  assign coords.z_coord = fifo_mem[rd_ptr].z;

endmodule

// File: test/idc_checker.sv
// Checker that predicts each Cartesian point from the accepted inputs and compares.
`timescale 1ns / 1ps

module idc_checker import idc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  idc_point_if        pts,
  idc_coord_if        crd,
  idc_cfg_if          cfg,
  output int          mismatches,
  output int          in_flight,
  output int          checked
);

  logic [RangeW-1:0] far_range;
  coord_t            coords_due[$];

  // Quarter-wave sine in Q30 for an offset 0..16384 within one quadrant.
  function automatic longint quarter_wave(int unsigned u);
    longint t, t2, p;
    t  = longint'(u) << 16;
    t2 = (t * t) >>> 30;
    p  = longint'(SinC9);
    p  = longint'(SinC7) + ((p * t2) >>> 30);
    p  = longint'(SinC5) + ((p * t2) >>> 30);
    p  = longint'(SinC3) + ((p * t2) >>> 30);
    p  = longint'(SinC1) + ((p * t2) >>> 30);
    p  = (p * t) >>> 30;
    if (p < 0) p = 0;
    if (p > longint'(Q30One)) p = longint'(Q30One);
    return p;
  endfunction

  function automatic longint sine_of(logic [AngW-1:0] a);
    longint s;
    s = a[14] ? quarter_wave(16384 - a[13:0]) : quarter_wave(a[13:0]);
    return a[15] ? -s : s;
  endfunction

  function automatic longint scale_q30(longint a, longint b);
    return (a * b + 64'sd536870912) >>> 30;
  endfunction

  function automatic coord_t coords_of(logic signed [InvW-1:0] inv,
                                       logic [AngW-1:0] yaw, logic [AngW-1:0] pitch);
    longint v, r, cy, sy, cp, sp;
    longint unsigned quo;
    coord_t c;
    v = longint'(inv);
    if (v < 0) begin
      r = longint'({1'b0, far_range});
    end else if (v == 0) begin
      r = 0;
    end else begin
      quo = ((64'd1 << 36) + (longint'(v) >> 1)) / longint'(v);
      r = (quo > 64'd2147483647) ? 64'd2147483647 : longint'(quo);
    end
    cy = sine_of(yaw + 16'd16384);
    sy = sine_of(yaw);
    cp = sine_of(pitch + 16'd16384);
    sp = sine_of(pitch);
    c.x = CoordW'(scale_q30(scale_q30(r, cy), cp));
    c.y = CoordW'(scale_q30(scale_q30(r, sy), cp));
    c.z = CoordW'(-scale_q30(r, sp));
    return c;
  endfunction

  assign in_flight = coords_due.size();

  always @(posedge clk) begin
    coord_t want;
    if (rst) begin
      far_range  <= FarRangeReset;
      mismatches <= 0;
      checked    <= 0;
      coords_due.delete();
    end else begin
      if (cfg.valid && cfg.ready) far_range <= cfg.far_range_value;
      if (pts.valid && pts.ready)
        coords_due.push_back(coords_of(pts.inverse_range, pts.yaw_angle, pts.pitch_angle));
      if (crd.valid && crd.ready) begin
        checked <= checked + 1;
        if (coords_due.size() == 0) begin
          $display("%0t: unexpected item x=%0d y=%0d z=%0d", $time,
                   crd.x_coord, crd.y_coord, crd.z_coord);
          mismatches <= mismatches + 1;
        end else begin
          want = coords_due.pop_front();
          if (want.x !== crd.x_coord || want.y !== crd.y_coord || want.z !== crd.z_coord) begin
            $display("%0t: mismatch expected x=%0d y=%0d z=%0d, actual x=%0d y=%0d z=%0d",
                     $time, want.x, want.y, want.z, crd.x_coord, crd.y_coord, crd.z_coord);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

endmodule

// File: test/tb_top.sv
// Stimulus, idling, configuration phases and verdict for the converter.
`timescale 1ns / 1ps

module tb_top import idc_pkg::*; ();

  localparam int StallLimit = 3000;
  localparam int Latency    = 60;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   mismatches, in_flight, checked;
  int   sent = 0, cfg_writes = 0, quiet_cycles = 0;
  bit   tx_idle = 1'b1, rx_idle = 1'b1, hold_req = 1'b0;

  idc_point_if pts();
  idc_coord_if crd();
  idc_cfg_if   cfg();

  inverse_depth_to_cartesian dut (.clk(clk), .rst(rst), .points(pts), .coords(crd), .cfg(cfg));
  idc_checker chk (.clk(clk), .rst(rst), .pts(pts), .crd(crd), .cfg(cfg),
                   .mismatches(mismatches), .in_flight(in_flight), .checked(checked));

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    pts.valid <= 1'b0;
    pts.inverse_range <= '0;
    pts.yaw_angle <= '0;
    pts.pitch_angle <= '0;
    crd.ready <= 1'b0;
    cfg.valid <= 1'b0;
    cfg.far_range_value <= '0;
  end

  // Watchdog on cycles where nothing moves on either data channel.
  always @(posedge clk) begin
    if ((pts.valid && pts.ready) || (crd.valid && crd.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("%0t: timeout, no item moved for %0d cycles", $time, quiet_cycles);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Receiver: random stall before each item while rx_idle is set, with one long hold-off on request.
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      gap = rx_idle ? $urandom_range(0, 11) : 0;
      if (hold_req) begin
        gap = 300;
        hold_req = 1'b0;
      end
      if (gap > 0) begin
        crd.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      crd.ready <= 1'b1;
      do @(posedge clk); while (!crd.valid);
    end
  end

  task automatic send_point(logic signed [InvW-1:0] inv, logic [AngW-1:0] yaw,
                            logic [AngW-1:0] pitch);
    int gap;
    gap = tx_idle ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      pts.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pts.valid <= 1'b1;
    pts.inverse_range <= inv;
    pts.yaw_angle <= yaw;
    pts.pitch_angle <= pitch;
    do @(posedge clk); while (!pts.ready);
    sent++;
  endtask

  // Lowers valid and waits until every expected point has come back.
  task automatic drain();
    pts.valid <= 1'b0;
    do @(posedge clk); while (in_flight != 0);
    repeat (Latency) @(posedge clk);
  endtask

  task automatic write_far(logic [RangeW-1:0] value);
    cfg.valid <= 1'b1;
    cfg.far_range_value <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    cfg_writes++;
  endtask

  function automatic logic [AngW-1:0] pick_angle();
    case ($urandom_range(0, 5))
      0: return 16'(($urandom_range(0, 3) << 14) + $urandom_range(0, 2) - 1);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random(int count);
    logic signed [InvW-1:0] inv;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0: inv = '0;
        1, 2: inv = -InvW'($urandom_range(1, 8388608));
        3, 4: inv = InvW'($urandom_range(1, 64));
        5, 6: inv = InvW'($urandom_range(1, 8388607));
        default: inv = InvW'($urandom);
      endcase
      send_point(inv, pick_angle(), pick_angle());
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Range corners: zero, negatives, saturation boundary, largest inverse range.
    send_point(24'sd0, 16'h4000, 16'h1234);
    send_point(-24'sd1, 16'h0000, 16'h0000);
    send_point(-24'sd8388608, 16'h8000, 16'h7FFF);
    send_point(24'sd8388607, 16'h7FFF, 16'h8000);
    send_point(24'sd1, 16'h2000, 16'hE000);
    send_point(24'sd31, 16'h0000, 16'h0000);
    send_point(24'sd32, 16'hC000, 16'h4000);
    send_point(24'sd33, 16'hFFFF, 16'h0001);
    send_point(24'sd1048576, 16'h4000, 16'hC000);
    send_point(24'sd3, 16'h3FFF, 16'h4001);
    send_point(24'sd2097152, 16'h8001, 16'hBFFF);
    send_point(24'sd699051, 16'hC001, 16'h5555);
    send_point(-24'sd4660, 16'hAAAA, 16'hFFFF);
    send_point(24'sd1048575, 16'h0001, 16'h8000);
    send_point(24'sd65536, 16'h1000, 16'hF000);
    send_point(24'sd4194304, 16'h5000, 16'h3000);
    drain();

    write_far('0);
    send_random(90);
    drain();

    // Long receiver hold-off with a back-to-back sender so the pipeline fills.
    write_far(RangeMax);
    tx_idle = 1'b0;
    hold_req = 1'b1;
    send_random(100);
    tx_idle = 1'b1;
    drain();

    write_far(RangeW'($urandom));
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_random(120);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    drain();

    write_far(FarRangeReset);
    send_random(120);
    drain();

    write_far(RangeW'(1));
    send_random(110);
    drain();

    $display("Sent %0d points and checked %0d results over %0d far-range settings,",
             sent, checked, cfg_writes + 1);
    $display("including a long output stall and stretches with no idling.");
    if (mismatches == 0 && in_flight == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
